// ----- src/rsa_pkg.sv -----
// Shared types and constants for the running statistics accumulator.
package rsa_pkg;

	localparam int DIGIT_W = 8;
	localparam logic [3:0] MASK_RESET = 4'hF;

	localparam int MASK_SUM  = 0;
	localparam int MASK_MAX  = 1;
	localparam int MASK_MIN  = 2;
	localparam int MASK_MEAN = 3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MEAN,
		ST_D2,
		ST_MUL,
		ST_DEV,
		ST_OUT
	} rsa_state_t;

	typedef struct packed {
		logic start;
		logic div_step;
		logic mean_upd;
		logic d2_load;
		logic mul_step;
		logic dev_upd;
		logic out_load;
	} rsa_cmd_t;

	typedef struct packed {
		logic track_mean;
	} rsa_stat_t;

endpackage

// ----- src/rsa_ctrl.sv -----
// Controller: per request, divide, mean update, multiply (mean on), result hand-off.
module rsa_ctrl import rsa_pkg::*; #(
	parameter int SAMPLE_WIDTH = 32,
	parameter int FRAC_BITS    = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  logic      m_tready,
	input  rsa_stat_t stat,
	output rsa_cmd_t  cmd
);
	localparam int MEAN_W = SAMPLE_WIDTH + FRAC_BITS;
	localparam int DIGITS = (MEAN_W + DIGIT_W - 1) / DIGIT_W;
	localparam int CNT_W  = $clog2(MEAN_W);

	rsa_state_t       state_q, state_nxt;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             accept;

	assign accept = (state_q == ST_IDLE) && s_tvalid;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_nxt = stat.track_mean ? ST_DIV : ST_OUT;
				end
			end
			ST_DIV: begin
				if (cnt_q == '0) begin
					state_nxt = ST_MEAN;
				end
			end
			ST_MEAN: state_nxt = ST_D2;
			ST_D2:   state_nxt = ST_MUL;
			ST_MUL: begin
				if (cnt_q == '0) begin
					state_nxt = ST_DEV;
				end
			end
			ST_DEV: state_nxt = ST_OUT;
			ST_OUT: begin
				if (!out_valid_q || m_tready) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.start    = accept;
		cmd.div_step = (state_q == ST_DIV);
		cmd.mean_upd = (state_q == ST_MEAN);
		cmd.d2_load  = (state_q == ST_D2);
		cmd.mul_step = (state_q == ST_MUL);
		cmd.dev_upd  = (state_q == ST_DEV);
		cmd.out_load = (state_q == ST_OUT) && (!out_valid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			out_valid_q <= cmd.out_load | (out_valid_q & ~m_tready);
			if (accept) begin
				cnt_q <= CNT_W'(MEAN_W - 1);
			end else if (state_q == ST_D2) begin
				cnt_q <= CNT_W'(DIGITS - 1);
			end else if ((state_q == ST_DIV) || (state_q == ST_MUL)) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

endmodule

// ----- src/rsa_datapath.sv -----
// Datapath: statistic registers, bit-serial divider, digit-serial multiplier, result register.
module rsa_datapath import rsa_pkg::*; #(
	parameter int SAMPLE_WIDTH = 32,
	parameter int FRAC_BITS    = 16,
	parameter int COUNT_WIDTH  = 32,
	parameter int OUT_W        = 272
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           mask_we,
	input  logic [3:0]                     mask_wdata,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  rsa_cmd_t                       cmd,
	output rsa_stat_t                      stat,
	output logic [OUT_W-1:0]               out_data
);
	localparam int MEAN_W = SAMPLE_WIDTH + FRAC_BITS;
	localparam int DIGITS = (MEAN_W + DIGIT_W - 1) / DIGIT_W;
	localparam int MPL_W  = DIGITS * DIGIT_W;
	localparam int ACC_W  = 2 * MEAN_W;
	localparam int SH_W   = ACC_W - FRAC_BITS;

	// architectural state
	logic [3:0]                     mask_q;
	logic [COUNT_WIDTH-1:0]         count_q;
	logic signed [63:0]             sum_q;
	logic signed [SAMPLE_WIDTH-1:0] min_q;
	logic signed [SAMPLE_WIDTH-1:0] max_q;
	logic signed [MEAN_W-1:0]       mean_q;
	logic [63:0]                    dev_q;

	// per-request working registers
	logic signed [MEAN_W-1:0] xq_q;
	logic                     d1neg_q;
	logic [MEAN_W-1:0]        dvd_q;
	logic [COUNT_WIDTH-1:0]   rem_q;
	logic [COUNT_WIDTH-1:0]   dvs_q;
	logic [MEAN_W-1:0]        mag_a_q;
	logic [MPL_W-1:0]         mpl_q;
	logic [ACC_W-1:0]         acc_q;
	logic [OUT_W-1:0]         out_data_q;

	logic [COUNT_WIDTH-1:0]   count_nxt;
	logic signed [MEAN_W-1:0] xq_in;
	logic [MEAN_W:0]          d1, d1_neg, d2, d2_neg;
	logic [MEAN_W-1:0]        d1_mag, d2_mag;
	logic [COUNT_WIDTH:0]     rem_sh, rem_diff;
	logic                     fits;
	logic [MEAN_W:0]          q_ext, q_signed, mean_sum;
	logic [DIGIT_W-1:0]       digit;
	logic [MEAN_W+DIGIT_W-1:0] pp;
	logic [SH_W+63:0]         sh_ext;
	logic                     ovf;
	logic [64:0]              dev_sum;

	assign count_nxt = (&count_q) ? count_q : count_q + 1'b1;
	assign xq_in     = {sample, {FRAC_BITS{1'b0}}};

	assign d1     = {xq_in[MEAN_W-1], xq_in} - {mean_q[MEAN_W-1], mean_q};
	assign d1_neg = -d1;
	assign d1_mag = d1[MEAN_W] ? d1_neg[MEAN_W-1:0] : d1[MEAN_W-1:0];

	// restoring divide, one quotient bit per step
	assign rem_sh   = {rem_q, dvd_q[MEAN_W-1]};
	assign fits     = (rem_sh >= {1'b0, dvs_q});
	assign rem_diff = rem_sh - {1'b0, dvs_q};

	assign q_ext    = {1'b0, dvd_q};
	assign q_signed = d1neg_q ? -q_ext : q_ext;
	assign mean_sum = {mean_q[MEAN_W-1], mean_q} + q_signed;

	// d2 shares the sign of d1 because the new mean lies between old mean and sample
	assign d2     = {xq_q[MEAN_W-1], xq_q} - {mean_q[MEAN_W-1], mean_q};
	assign d2_neg = -d2;
	assign d2_mag = d2[MEAN_W] ? d2_neg[MEAN_W-1:0] : d2[MEAN_W-1:0];

	// multiply top digit first so the accumulator only shifts left
	assign digit = mpl_q[MPL_W-1 -: DIGIT_W];
	assign pp    = mag_a_q * digit;

	assign sh_ext  = {64'b0, acc_q[ACC_W-1:FRAC_BITS]};
	assign ovf     = |sh_ext[SH_W+63:64];
	assign dev_sum = {1'b0, dev_q} + {1'b0, sh_ext[63:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= MASK_RESET;
			count_q <= '0;
			sum_q   <= '0;
			min_q   <= {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
			max_q   <= {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
			mean_q  <= '0;
			dev_q   <= '0;
		end else begin
			if (mask_we) begin
				mask_q <= mask_wdata;
			end
			if (cmd.start) begin
				count_q <= count_nxt;
				if (mask_q[MASK_SUM]) begin
					sum_q <= sum_q + 64'(sample);
				end
				if (mask_q[MASK_MAX] && (sample > max_q)) begin
					max_q <= sample;
				end
				if (mask_q[MASK_MIN] && (sample < min_q)) begin
					min_q <= sample;
				end
			end
			if (cmd.mean_upd) begin
				mean_q <= mean_sum[MEAN_W-1:0];
			end
			if (cmd.dev_upd) begin
				dev_q <= (ovf || dev_sum[64]) ? '1 : dev_sum[63:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			xq_q    <= xq_in;
			d1neg_q <= d1[MEAN_W];
			dvd_q   <= d1_mag;
			mag_a_q <= d1_mag;
			rem_q   <= '0;
			dvs_q   <= count_nxt;
		end
		if (cmd.div_step) begin
			rem_q <= fits ? rem_diff[COUNT_WIDTH-1:0] : rem_sh[COUNT_WIDTH-1:0];
			dvd_q <= {dvd_q[MEAN_W-2:0], fits};
		end
		if (cmd.d2_load) begin
			mpl_q <= MPL_W'(d2_mag);
			acc_q <= '0;
		end
		if (cmd.mul_step) begin
			acc_q <= (acc_q << DIGIT_W) + ACC_W'(pp);
			mpl_q <= mpl_q << DIGIT_W;
		end
		if (cmd.out_load) begin
			out_data_q <= OUT_W'({dev_q, mean_q, max_q, min_q, sum_q, count_q});
		end
	end

	assign stat.track_mean = mask_q[MASK_MEAN];
	assign out_data        = out_data_q;

endmodule

// ----- src/running_statistics_accumulator_top.sv -----
// Top level of the running statistics accumulator: count, sum, min, max, mean, deviation sum.
// With mean tracking off, a request goes straight to the result hand-off; with it on,
// the block first runs one divider step per mean bit, the mean update, the deviation load,
// then one multiply step per 8-bit digit of the deviation and the deviation-sum update.
// A new request is taken once the previous result is registered, even while that result still waits.
// Reset (arst_n low) clears all statistics at once and sets the mask to all enabled.
module running_statistics_accumulator_top import rsa_pkg::*; #(
	parameter int SAMPLE_WIDTH = 32,
	parameter int FRAC_BITS    = 16,
	parameter int COUNT_WIDTH  = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 mask_we,
	input  logic [3:0]           mask_wdata,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata, // sample
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// sample_count, running_sum, running_min, running_max, running_mean, squared_deviation_sum
	output logic [((COUNT_WIDTH+3*SAMPLE_WIDTH+FRAC_BITS+128+7)/8)*8-1:0] m_tdata
);
	localparam int OUT_W = ((COUNT_WIDTH + 3*SAMPLE_WIDTH + FRAC_BITS + 128 + 7) / 8) * 8;

	rsa_cmd_t  cmd;
	rsa_stat_t stat;

	rsa_ctrl #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	rsa_datapath #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.FRAC_BITS   (FRAC_BITS),
		.COUNT_WIDTH (COUNT_WIDTH),
		.OUT_W       (OUT_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.mask_we   (mask_we),
		.mask_wdata(mask_wdata),
		.sample    ($signed(s_tdata[SAMPLE_WIDTH-1:0])),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (m_tdata)
	);

endmodule

// ----- src/rsa_checker.sv -----
// Port-level checks for the running statistics accumulator, bound to the top level.
module rsa_checker #(
	parameter int COUNT_WIDTH = 32,
	parameter int OUT_W       = 272
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one request at a time: busy right after a request is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	// a result never appears in the cycle right after a request
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result appeared too early");

	// a result always counts at least the request that caused it
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[COUNT_WIDTH-1:0] != '0)
		else $error("result with zero count");

	// block is free again as soon as a result is posted
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("not ready after posting result");

endmodule

bind running_statistics_accumulator_top rsa_checker #(
	.COUNT_WIDTH(COUNT_WIDTH),
	.OUT_W      (OUT_W)
) u_rsa_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

// ----- tb/sv/running_statistics_accumulator_top_test.sv -----
// Self-checking testbench for the running statistics accumulator top level.
`timescale 1ns / 1ps

import rsa_pkg::*;

typedef struct {
	logic [31:0] count;
	logic [63:0] sum;
	logic [31:0] min;
	logic [31:0] max;
	logic [47:0] mean;
	logic [63:0] dev;
} stats_result_t;

class stats_scoreboard;
	logic [3:0]      mask;
	longint unsigned count;
	logic [63:0]     total;
	int              lowest;
	int              highest;
	longint          mean_q;
	logic [63:0]     dev_sum;
	stats_result_t   expected[$];
	int              mismatches;
	int              checked;
	bit              dev_saturated;

	function new();
		mask = MASK_RESET;
		count = 0;
		total = '0;
		lowest = 32'sh7FFF_FFFF;
		highest = 32'sh8000_0000;
		mean_q = 0;
		dev_sum = '0;
		mismatches = 0;
		checked = 0;
		dev_saturated = 0;
	endfunction

	function void set_mask(logic [3:0] value);
		mask = value;
	endfunction

	function int pending();
		return expected.size();
	endfunction

	// Update the statistics for one accepted request and queue the result it must give.
	function void note_sample(logic [31:0] raw);
		int              x;
		longint          xq;
		longint          d1;
		longint          d2;
		longint unsigned m1;
		longint unsigned m2;
		logic [127:0]    prod;
		logic [63:0]     add;
		logic [64:0]     acc;
		stats_result_t   r;
		x = raw;
		if (count < 64'hFFFF_FFFF)
			count++;
		if (mask[MASK_SUM])
			total = total + longint'(x);
		if (mask[MASK_MAX] && x > highest)
			highest = x;
		if (mask[MASK_MIN] && x < lowest)
			lowest = x;
		if (mask[MASK_MEAN]) begin
			xq = longint'(x) * 65536;
			d1 = xq - mean_q;
			mean_q = mean_q + d1 / longint'(count);
			d2 = xq - mean_q;
			if (((d1 >= 0) == (d2 >= 0)) || d1 == 0 || d2 == 0) begin
				m1 = (d1 < 0) ? -d1 : d1;
				m2 = (d2 < 0) ? -d2 : d2;
				prod = {64'd0, m1} * {64'd0, m2};
				// product is kept exact; anything above 64 bits after the shift saturates
				if (prod[127:80] != '0)
					add = '1;
				else
					add = prod[79:16];
				acc = {1'b0, dev_sum} + {1'b0, add};
				dev_sum = acc[64] ? '1 : acc[63:0];
			end
		end
		if (&dev_sum)
			dev_saturated = 1;
		r.count = count[31:0];
		r.sum = total;
		r.min = lowest;
		r.max = highest;
		r.mean = mean_q[47:0];
		r.dev = dev_sum;
		expected = {expected, r};
	endfunction

	function void compare_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on result %0d, %s: expected %h, got %h",
					checked, name, want, got);
		end
	endfunction

	function void check_result(logic [271:0] data);
		stats_result_t want;
		if (expected.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result with nothing expected: %h", data);
			return;
		end
		want = expected.pop_front();
		compare_field("sample_count", want.count, data[31:0]);
		compare_field("running_sum", want.sum, data[95:32]);
		compare_field("running_min", want.min, data[127:96]);
		compare_field("running_max", want.max, data[159:128]);
		compare_field("running_mean", want.mean, data[207:160]);
		compare_field("squared_deviation_sum", want.dev, data[271:208]);
		checked++;
	endfunction
endclass

module running_statistics_accumulator_top_test;

	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int PHASE_ITEMS  = 160;
	localparam int FINAL_ITEMS  = 150;
	localparam int SETTLE       = 70;

	logic         clk;
	logic         arst_n;
	logic         mask_we;
	logic [3:0]   mask_wdata;
	logic         s_tvalid;
	logic         s_tready;
	logic [31:0]  s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [271:0] m_tdata;

	stats_scoreboard book;
	bit              idle_on;
	bit              hold_request;
	int              cycle_count;
	int              sent;
	int              settings;

	running_statistics_accumulator_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.mask_we    (mask_we),
		.mask_wdata (mask_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("FAIL running_statistics_accumulator_top");
		$finish;
	end

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		int held;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				m_tready <= 1'b0;
				for (held = 0; held < HOLD_CYCLES; held++)
					@(negedge clk);
				hold_request = 0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 10) - 1) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			book.check_result(m_tdata);
	end

	function automatic logic [31:0] pick_sample(input bit narrow);
		logic [31:0] mag;
		int          w;
		if (narrow) begin
			// keep the deviation sum clear of saturation while the mean is tracked
			w = $urandom_range(0, 17);
			mag = $urandom & ((32'd1 << w) - 1);
			return $urandom_range(0, 1) ? -mag : mag;
		end
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0000_0000;
			4: return $urandom_range(0, 255) - 128;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_sample(input logic [31:0] value);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= value;
		do @(posedge clk); while (!s_tready);
		book.note_sample(value);
		sent++;
	endtask

	task automatic sender_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (book.pending() != 0)
			@(posedge clk);
	endtask

	// Write the mask only with the block idle and every result delivered.
	task automatic write_mask(input logic [3:0] value);
		sender_idle();
		wait_drained();
		repeat (8) @(posedge clk);
		@(negedge clk);
		mask_we <= 1'b1;
		mask_wdata <= value;
		@(negedge clk);
		mask_we <= 1'b0;
		book.set_mask(value);
		settings++;
	endtask

	initial begin
		logic [3:0] phase_mask[8];
		int         p;
		int         i;
		arst_n = 1'b0;
		mask_we = 1'b0;
		mask_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		idle_on = 1;
		hold_request = 0;
		sent = 0;
		settings = 0;
		book = new();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// first sample sets the mean directly; a repeat gives zero deviation
		write_mask(4'hF);
		send_sample(32'd1000);
		send_sample(32'd1000);
		send_sample(-32'd1000);
		send_sample(32'd0);
		send_sample(32'd1);
		send_sample(32'hFFFF_FFFF);

		// field extremes with mean tracking off
		write_mask(4'h7);
		send_sample(32'h8000_0000);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'hFFFF_FFFF);
		send_sample(32'h0000_0000);
		send_sample(32'h5555_5555);
		send_sample(32'hAAAA_AAAA);
		send_sample(32'h0000_0001);

		// everything off: only the count moves
		write_mask(4'h0);
		send_sample(32'h1234_5678);
		send_sample(32'h8000_0000);

		// mean alone, enabled late against the full count
		write_mask(4'h8);
		send_sample(32'd5);
		send_sample(-32'd7);

		phase_mask = '{4'hF, 4'h0, 4'h7, 4'hA, 4'h0, 4'h5, 4'hC, 4'h0};
		phase_mask[4] = 4'($urandom_range(1, 14));
		phase_mask[7] = 4'($urandom_range(1, 14));
		for (p = 0; p < 8; p++) begin
			idle_on = (p % 3 != 2);
			write_mask(phase_mask[p]);
			for (i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 3 && i == 20)
					hold_request = 1;
				if (p == 5 && i == 80) begin
					sender_idle();
					wait_drained();
				end
				send_sample(pick_sample(phase_mask[p][MASK_MEAN]));
			end
		end

		// full-range samples with everything tracked drive the deviation sum into saturation
		idle_on = 0;
		write_mask(4'hF);
		for (i = 0; i < FINAL_ITEMS; i++)
			send_sample(pick_sample(0));

		sender_idle();
		wait_drained();
		repeat (SETTLE) @(posedge clk);

		$display("%0d samples sent, %0d results checked, %0d mask settings, %0d mismatches",
			sent, book.checked, settings, book.mismatches);
		$display("deviation sum reached saturation: %0d", book.dev_saturated);
		if (book.mismatches == 0 && book.pending() == 0)
			$display("PASS running_statistics_accumulator_top");
		else
			$display("FAIL running_statistics_accumulator_top");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/rsa_pkg.sv
src/rsa_ctrl.sv
src/rsa_datapath.sv
src/running_statistics_accumulator_top.sv
src/rsa_checker.sv
tb/sv/running_statistics_accumulator_top_test.sv
